// ----- hw/rtl/frf_pkg.sv -----
// shared types, constants and fixed-point helpers of the reflectance block
package frf_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(TABLE_DEPTH);

	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic [31:0] e;
		logic [30:0] b;
		logic [30:0] d;
	} entry_t;

	typedef enum logic [1:0] {
		OP_SQRT,
		OP_RATIO,
		OP_LDIV
	} itr_op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RD0W,
		S_RDLW,
		S_SCAND,
		S_LB,
		S_LBD,
		S_LD,
		S_LDD,
		S_NRR,
		S_BB,
		S_NB,
		S_CC,
		S_X2,
		S_Y2,
		S_MAG,
		S_RR,
		S_RI,
		S_TA,
		S_TB,
		S_BA,
		S_BI,
		S_RAT,
		S_CN,
		S_CI,
		S_FIN
	} state_t;

	// round half up then floor shift by 30
	function automatic logic [63:0] rshr30(input logic [63:0] x);
		logic [63:0] y;
		y = x + (64'd1 << 29);
		return {{30{y[63]}}, y[63:30]};
	endfunction

	// round half up then floor shift by 2
	function automatic logic [63:0] rshr2(input logic [63:0] x);
		logic [63:0] y;
		y = x + 64'd2;
		return {{2{y[63]}}, y[63:2]};
	endfunction

endpackage

// ----- hw/rtl/fresnel_reflectivity_interp.sv -----
// fresnel reflectance of an interpolated optical constant table
// load beats write the table while idle; a query holds in_ready low until its result
// is registered; a ratio is capped at one; a clamped query skips the scan and the
// interpolation; one shared 32x32 multiplier and one bit-serial unit do the arithmetic,
// one operation at a time
// asynchronous reset clears control and sets used_q to 1; table is not cleared
module fresnel_reflectivity_interp (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  entry_index,
	input  logic [31:0] energy,
	input  logic [30:0] beta_value,
	input  logic [30:0] delta_value,
	input  logic [31:0] cos_angle,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] reflectivity,
	output logic        clamped,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata
);
	import frf_pkg::*;

	state_t state_q, state_d;
	logic   issued_q;
	logic   mul_go, itr_go, mul_done, itr_done;
	logic   [63:0] mul_a, mul_b, mul_p, itr_a, itr_b, itr_res;
	itr_op_t itr_op;

	logic [8:0]       used_q;
	logic             tbl_we;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd, wentry;

	logic [31:0]      e_q;
	logic [30:0]      c_q, ab_q, ad_q, qs_q, qp_q;
	logic [IDX_W-1:0] last_q, k_q;
	entry_t           prev_q, cur_q;
	logic             clamp_q, pass_q;
	logic [63:0]      t_q, top_q, nsr_q, nsi_q, x_q, mag_q, rr_q, ri_q, pr_q, pi_q;

	logic             out_valid_q, out_clamp_q;
	logic [30:0]      out_refl_q;

	logic [63:0] x28, y28, nr, cx, bx, dvb, dvd, de, span, tabs;
	logic [32:0] cabs;
	logic [30:0] csat;
	logic [IDX_W-1:0] last_new;
	logic        accept, scan_more, fin_go;

	assign accept = in_valid && in_ready;
	assign tbl_we = accept && (action == ACT_LOAD) && (int'(entry_index) < TABLE_DEPTH);
	assign wentry = '{e: energy, b: beta_value, d: delta_value};

	assign x28 = rshr2(x_q);
	assign y28 = rshr2(nsi_q);
	assign nr = ONE_Q30 - {33'd0, ad_q};
	assign cx = {33'd0, c_q};
	assign bx = {33'd0, ab_q};
	assign dvb = {33'd0, cur_q.b} - {33'd0, prev_q.b};
	assign dvd = {33'd0, cur_q.d} - {33'd0, prev_q.d};
	assign de = {32'd0, e_q} - {32'd0, prev_q.e};
	assign span = {32'd0, cur_q.e} - {32'd0, prev_q.e};
	assign tabs = t_q[63] ? (64'd0 - t_q) : t_q;
	assign scan_more = (k_q < last_q) && (rd.e < e_q);
	assign fin_go = !out_valid_q || out_ready;

	assign cabs = cos_angle[31] ? (33'd0 - {1'b1, cos_angle}) : {1'b0, cos_angle};
	assign csat = (cabs > 33'(ONE_Q30)) ? 31'(ONE_Q30) : cabs[30:0];

	always_comb begin
		if (used_q == 9'd0) begin
			last_new = '0;
		end else if (int'(used_q) > TABLE_DEPTH) begin
			last_new = IDX_W'(TABLE_DEPTH - 1);
		end else begin
			last_new = IDX_W'(used_q - 9'd1);
		end
	end

	frf_table u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (IDX_W'(entry_index)),
		.wdata (wentry),
		.raddr (rd_addr),
		.rdata (rd)
	);

	frf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	frf_itr u_itr (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (itr_go),
		.op     (itr_op),
		.a      (itr_a),
		.b      (itr_b),
		.done   (itr_done),
		.res    (itr_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issued_q <= 1'b0;
			used_q <= 9'd1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_done || itr_done) begin
				issued_q <= 1'b0;
			end else if (mul_go || itr_go) begin
				issued_q <= 1'b1;
			end
			if (cfg_we) begin
				used_q <= cfg_wdata;
			end
			if (state_q == S_FIN && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		rd_addr = '0;
		mul_go = 1'b0;
		mul_a = 64'd0;
		mul_b = 64'd0;
		itr_go = 1'b0;
		itr_op = OP_SQRT;
		itr_a = 64'd0;
		itr_b = 64'd0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (accept && action == ACT_QUERY) state_d = S_RD0W;
			end
			S_RD0W: begin
				rd_addr = last_q;
				state_d = (e_q < rd.e) ? S_NRR : S_RDLW;
			end
			S_RDLW: begin
				rd_addr = IDX_W'(1);
				state_d = (e_q > rd.e || last_q == '0) ? S_NRR : S_SCAND;
			end
			S_SCAND: begin
				rd_addr = k_q + IDX_W'(1);
				if (!scan_more) begin
					state_d = (e_q >= rd.e || e_q <= prev_q.e) ? S_NRR : S_LB;
				end
			end
			S_LB, S_LD: begin
				mul_go = !issued_q;
				mul_a = (state_q == S_LB) ? dvb : dvd;
				mul_b = de;
				if (mul_done) state_d = (state_q == S_LB) ? S_LBD : S_LDD;
			end
			S_LBD, S_LDD: begin
				itr_go = !issued_q;
				itr_op = OP_LDIV;
				itr_a = tabs;
				itr_b = span;
				if (itr_done) state_d = (state_q == S_LBD) ? S_LD : S_NRR;
			end
			S_NRR, S_BB, S_NB, S_CC, S_X2, S_Y2, S_TA, S_TB, S_BA, S_BI, S_CN, S_CI: begin
				mul_go = !issued_q;
				case (state_q)
					S_NRR: begin mul_a = nr; mul_b = nr; state_d = mul_done ? S_BB : state_q; end
					S_BB: begin mul_a = bx; mul_b = bx; state_d = mul_done ? S_NB : state_q; end
					S_NB: begin mul_a = nr; mul_b = bx; state_d = mul_done ? S_CC : state_q; end
					S_CC: begin mul_a = cx; mul_b = cx; state_d = mul_done ? S_X2 : state_q; end
					S_X2: begin mul_a = x28; mul_b = x28; state_d = mul_done ? S_Y2 : state_q; end
					S_Y2: begin mul_a = y28; mul_b = y28; state_d = mul_done ? S_MAG : state_q; end
					S_TA: begin
						mul_a = rshr2(pr_q - rr_q);
						mul_b = mul_a;
						state_d = mul_done ? S_TB : state_q;
					end
					S_TB: begin
						mul_a = rshr2(pi_q - ri_q);
						mul_b = mul_a;
						state_d = mul_done ? S_BA : state_q;
					end
					S_BA: begin
						mul_a = rshr2(pr_q + rr_q);
						mul_b = mul_a;
						state_d = mul_done ? S_BI : state_q;
					end
					S_BI: begin
						mul_a = rshr2(pi_q + ri_q);
						mul_b = mul_a;
						state_d = mul_done ? S_RAT : state_q;
					end
					S_CN: begin mul_a = cx; mul_b = nsr_q; state_d = mul_done ? S_CI : state_q; end
					default: begin mul_a = cx; mul_b = nsi_q; state_d = mul_done ? S_TA : state_q; end
				endcase
			end
			S_MAG, S_RR, S_RI: begin
				itr_go = !issued_q;
				itr_op = OP_SQRT;
				case (state_q)
					S_MAG: begin itr_a = t_q; state_d = itr_done ? S_RR : state_q; end
					S_RR: begin itr_a = (mag_q + x28) << 31; state_d = itr_done ? S_RI : state_q; end
					default: begin itr_a = (mag_q - x28) << 31; state_d = itr_done ? S_TA : state_q; end
				endcase
			end
			S_RAT: begin
				itr_go = !issued_q;
				itr_op = OP_RATIO;
				itr_a = top_q;
				itr_b = t_q;
				if (itr_done) state_d = pass_q ? S_FIN : S_CN;
			end
			S_FIN: begin
				if (fin_go) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (accept && action == ACT_QUERY) begin
				e_q <= energy;
				c_q <= csat;
				last_q <= last_new;
				k_q <= IDX_W'(1);
				clamp_q <= 1'b0;
				pass_q <= 1'b0;
			end
			S_RD0W: begin
				prev_q <= rd;
				if (e_q < rd.e) begin
					ab_q <= rd.b;
					ad_q <= rd.d;
					clamp_q <= 1'b1;
				end
			end
			S_RDLW: begin
				if (e_q > rd.e) begin
					ab_q <= rd.b;
					ad_q <= rd.d;
					clamp_q <= 1'b1;
				end else if (last_q == '0) begin
					ab_q <= prev_q.b;
					ad_q <= prev_q.d;
				end
			end
			S_SCAND: begin
				if (scan_more) begin
					prev_q <= rd;
					k_q <= k_q + IDX_W'(1);
				end else if (e_q >= rd.e) begin
					ab_q <= rd.b;
					ad_q <= rd.d;
				end else if (e_q <= prev_q.e) begin
					ab_q <= prev_q.b;
					ad_q <= prev_q.d;
				end else begin
					cur_q <= rd;
				end
			end
			S_LB, S_LD, S_NRR, S_X2, S_TA, S_BA: if (mul_done) t_q <= mul_p;
			S_LBD: if (itr_done) begin
				ab_q <= 31'({33'd0, prev_q.b} + (t_q[63] ? (64'd0 - itr_res) : itr_res));
			end
			S_LDD: if (itr_done) begin
				ad_q <= 31'({33'd0, prev_q.d} + (t_q[63] ? (64'd0 - itr_res) : itr_res));
			end
			S_BB: if (mul_done) nsr_q <= rshr30(t_q - mul_p);
			S_NB: if (mul_done) nsi_q <= rshr30({mul_p[62:0], 1'b0});
			S_CC: if (mul_done) begin
				x_q <= nsr_q - (ONE_Q30 - rshr30(mul_p));
				pr_q <= cx;
				pi_q <= 64'd0;
			end
			S_Y2, S_BI: if (mul_done) t_q <= t_q + mul_p;
			S_TB: if (mul_done) top_q <= t_q + mul_p;
			S_MAG: if (itr_done) mag_q <= itr_res;
			S_RR: if (itr_done) rr_q <= itr_res;
			S_RI: if (itr_done) ri_q <= nsi_q[63] ? (64'd0 - itr_res) : itr_res;
			S_RAT: if (itr_done) begin
				if (pass_q) begin
					qp_q <= itr_res[30:0];
				end else begin
					qs_q <= itr_res[30:0];
				end
				pass_q <= 1'b1;
			end
			S_CN: if (mul_done) pr_q <= rshr30(mul_p);
			S_CI: if (mul_done) pi_q <= rshr30(mul_p);
			S_FIN: if (fin_go) begin
				out_refl_q <= 31'(({1'b0, qs_q} + {1'b0, qp_q}) >> 1);
				out_clamp_q <= clamp_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign reflectivity = out_refl_q;
	assign clamped = out_clamp_q;

endmodule

// ----- hw/rtl/frf_table.sv -----
// optical constant table: one write port, one registered read port
module frf_table (
	input  logic                             clk,
	input  logic                             we,
	input  logic [frf_pkg::IDX_W-1:0]        waddr,
	input  frf_pkg::entry_t                  wdata,
	input  logic [frf_pkg::IDX_W-1:0]        raddr,
	output frf_pkg::entry_t                  rdata
);
	import frf_pkg::*;

	entry_t mem_q [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/frf_mul.sv -----
// 64 by 64 bit product modulo 2^64 from three passes of one 32 by 32 multiplier
module frf_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);
	import frf_pkg::*;

	logic [2:0]  ph_q;
	logic [63:0] a_q, b_q, prod_q, acc_q;
	logic        done_q;
	logic [31:0] ma, mb;
	logic [63:0] mprod;

	assign ma = (ph_q == 3'd3) ? a_q[63:32] : a_q[31:0];
	assign mb = (ph_q == 3'd2) ? b_q[63:32] : b_q[31:0];
	assign mprod = ma * mb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				3'd0: if (start) ph_q <= 3'd1;
				3'd4: begin
					ph_q <= 3'd0;
					done_q <= 1'b1;
				end
				default: ph_q <= ph_q + 3'd1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			3'd0: if (start) begin
				a_q <= a;
				b_q <= b;
			end
			3'd1: prod_q <= mprod;
			3'd2: begin
				acc_q <= prod_q;
				prod_q <= mprod;
			end
			3'd3: begin
				acc_q <= acc_q + {prod_q[31:0], 32'd0};
				prod_q <= mprod;
			end
			3'd4: acc_q <= acc_q + {prod_q[31:0], 32'd0};
			default: ;
		endcase
	end

	assign done = done_q;
	assign p = acc_q;

endmodule

// ----- hw/rtl/frf_itr.sv -----
// bit-serial unit for integer square root, fraction ratio and long division
module frf_itr (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  frf_pkg::itr_op_t op,
	input  logic [63:0]      a,
	input  logic [63:0]      b,
	output logic             done,
	output logic [63:0]      res
);
	import frf_pkg::*;

	itr_op_t     op_q;
	logic        busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q, d_q, res_q, bit_q;
	logic [31:0] nlo_q;
	logic [63:0] sum, sh;

	assign sum = res_q + bit_q;
	assign sh = {rem_q[62:0], (op_q == OP_LDIV) ? nlo_q[31] : 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				case (op)
					OP_SQRT: begin
						busy_q <= 1'b1;
						cnt_q <= 6'd32;
					end
					OP_RATIO: begin
						busy_q <= (a < b);
						done_q <= (a >= b);
						cnt_q <= 6'd30;
					end
					default: begin
						busy_q <= 1'b1;
						cnt_q <= 6'd32;
					end
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q <= op;
			d_q <= b;
			bit_q <= 64'd1 << 62;
			nlo_q <= a[31:0];
			case (op)
				OP_SQRT: begin
					rem_q <= a;
					res_q <= 64'd0;
				end
				OP_RATIO: begin
					rem_q <= a;
					res_q <= (a >= b) ? ONE_Q30 : 64'd0;
				end
				default: begin
					rem_q <= {32'd0, a[63:32]};
					res_q <= 64'd0;
				end
			endcase
		end else if (busy_q) begin
			if (op_q == OP_SQRT) begin
				if (rem_q >= sum) begin
					rem_q <= rem_q - sum;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				if (sh >= d_q) begin
					rem_q <= sh - d_q;
					res_q <= {res_q[62:0], 1'b1};
				end else begin
					rem_q <= sh;
					res_q <= {res_q[62:0], 1'b0};
				end
				nlo_q <= {nlo_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule
